// ===== sv/sprite_xor_framebuffer_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SPRITE_XOR_FRAMEBUFFER_TOP_DEFINES_SVH
`define SPRITE_XOR_FRAMEBUFFER_TOP_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define SXF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define SXF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sxf_pkg.sv =====
package sxf_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int SPRITE_BITS   = 8;

  localparam int COL_W = $clog2(SCREEN_WIDTH);
  localparam int ROW_W = $clog2(SCREEN_HEIGHT);

  // x_pos (6 bits) plus a sprite bit offset, and y_pos (5 bits) plus row_index (4 bits)
  localparam int COL_SUM_W = 7;
  localparam int ROW_SUM_W = 6;
  localparam int COL_TAB_N = 1 << COL_SUM_W;
  localparam int ROW_TAB_N = 1 << ROW_SUM_W;

  localparam logic [1:0] FUNC_DRAW = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  typedef logic [SCREEN_WIDTH-1:0] line_t;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] x_pos;
    logic [4:0] y_pos;
    logic [3:0] row_index;
    logic [7:0] sprite_row;
    logic       last_row;
  } sxf_item_t;

  typedef struct packed {
    logic pixel_on;
    logic collision;
  } sxf_result_t;

  typedef logic [COL_W-1:0] col_tab_t [COL_TAB_N];
  typedef logic [ROW_W-1:0] row_tab_t [ROW_TAB_N];

  // Wrap tables: entry v holds v modulo the screen size, built by counting.
  function automatic col_tab_t build_col_tab();
    col_tab_t t;
    int c;
    int v;
    c = 0;
    for (v = 0; v < COL_TAB_N; v++) begin
      t[v] = COL_W'(c);
      c = (c == SCREEN_WIDTH - 1) ? 0 : c + 1;
    end
    return t;
  endfunction

  function automatic row_tab_t build_row_tab();
    row_tab_t t;
    int c;
    int v;
    c = 0;
    for (v = 0; v < ROW_TAB_N; v++) begin
      t[v] = ROW_W'(c);
      c = (c == SCREEN_HEIGHT - 1) ? 0 : c + 1;
    end
    return t;
  endfunction

  localparam col_tab_t COL_WRAP = build_col_tab();
  localparam row_tab_t ROW_WRAP = build_row_tab();

endpackage

// ===== sv/sxf_mask.sv =====
module sxf_mask
  import sxf_pkg::*;
(
  input  logic [5:0] x_pos,
  input  logic [7:0] sprite_row,
  output line_t      mask
);

  // Place each lit sprite bit at its wrapped column; bit 7 lands on x_pos.
  always_comb begin
    mask = '0;
    for (int i = 0; i < SPRITE_BITS; i++) begin
      if (sprite_row[SPRITE_BITS-1-i]) begin
        mask[COL_WRAP[COL_SUM_W'(x_pos) + COL_SUM_W'(i)]] = 1'b1;
      end
    end
  end

endmodule

// ===== sv/sxf_frame.sv =====
module sxf_frame
  import sxf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sxf_item_t   item,
  input  logic        fire,
  input  line_t       mask,
  output sxf_result_t result
);

  line_t                    frame [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] row_valid;
  logic                     collision_accum;
  logic                     collision_accum_next;

  logic [ROW_SUM_W-1:0] row_sum;
  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  line_t                line;
  line_t                line_next;
  line_t                pixel_bit;
  logic                 hit;
  logic                 write_en;

  always_comb begin
    row_sum = ROW_SUM_W'(item.y_pos);
    if (item.func == FUNC_DRAW) begin
      row_sum = ROW_SUM_W'(item.y_pos) + ROW_SUM_W'(item.row_index);
    end
    row       = ROW_WRAP[row_sum];
    col       = COL_WRAP[COL_SUM_W'(item.x_pos)];
    // A row never written since reset reads as all pixels off.
    line      = row_valid[row] ? frame[row] : '0;
    pixel_bit = line_t'(1) << col;
    hit       = |(line & mask);
  end

  always_comb begin
    line_next            = line;
    write_en             = 1'b0;
    collision_accum_next = collision_accum;
    result               = '0;
    case (item.func)
      FUNC_DRAW: begin
        line_next            = line ^ mask;
        write_en             = 1'b1;
        collision_accum_next = (item.row_index == '0) ? hit : (collision_accum | hit);
        result.collision     = item.last_row & collision_accum_next;
      end
      FUNC_SET: begin
        line_next = line | pixel_bit;
        write_en  = 1'b1;
      end
      FUNC_READ: begin
        result.pixel_on = line[col];
      end
      default: begin
        write_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid       <= '0;
      collision_accum <= 1'b0;
    end else if (fire) begin
      collision_accum <= collision_accum_next;
      if (write_en) begin
        row_valid[row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && write_en) begin
      frame[row] <= line_next;
    end
  end

endmodule

// ===== sv/sprite_xor_framebuffer_top.sv =====
// One-bit-per-pixel framebuffer, SCREEN_WIDTH by SCREEN_HEIGHT, all pixels off
// after reset. Each item beat runs one operation: draw one sprite row (XOR the
// byte, bit 7 leftmost, at row y_pos + row_index from column x_pos, wrapping
// at the screen edges), set one pixel, or read one pixel. Every item gives
// exactly one result beat: pixel_on for a read, and on a draw marked last_row
// the collision flag gathered over the sprite since its row_index 0 row. The
// block takes one item per clock while the consumer takes each result beat;
// an accepted item waits in the item register, then its result is registered.
// That rate is set by the single read-modify-write of one frame row between
// the item register and the result register, so back-to-back items always
// see each other's updates. No clearing pass is needed after reset: per-row
// valid bits make untouched rows read as off at once.
module sprite_xor_framebuffer_top
  import sxf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  sxf_item_t   item,
  output logic        result_valid,
  input  logic        result_ready,
  output sxf_result_t result
);

  // Item register: holds one accepted beat until the frame update runs.
  logic        held_valid;
  sxf_item_t   held;
  logic        fire;
  line_t       mask;
  sxf_result_t result_next;

  // Run the held item whenever the result register is empty or draining.
  assign fire       = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      held <= item;
    end
  end

  sxf_mask u_mask (
    .x_pos      (held.x_pos),
    .sprite_row (held.sprite_row),
    .mask       (mask)
  );

  sxf_frame u_frame (
    .clk    (clk),
    .rst    (rst),
    .item   (held),
    .fire   (fire),
    .mask   (mask),
    .result (result_next)
  );

  // Result register: hold the beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

endmodule

// ===== sv/sxf_checker.sv =====
`include "sprite_xor_framebuffer_top_defines.svh"

module sxf_checker
  import sxf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input sxf_result_t result
);

  `SXF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

  `SXF_ASSERT_NOW(a_no_result_after_reset, $fell(rst), !result_valid, "result beat present right after reset")

  `SXF_ASSERT_NOW(a_read_no_collision, result_valid, !(result.pixel_on && result.collision), "pixel_on and collision both set in one beat")

  `SXF_ASSERT_NOW(a_result_has_item, $rose(result_valid), $past(item_valid && item_ready, 2), "result beat without an accepted item")

endmodule

bind sprite_xor_framebuffer_top sxf_checker u_sxf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
